/* rtl/arpl_pkg.sv */
// ----------------------------------------------------------------------------
// arpl_pkg
// Shared types and constants of the adaptive-release peak limiter: fixed-point
// coefficients, register indexes, sequencer states and control words.
// ----------------------------------------------------------------------------
`default_nettype none

package arpl_pkg;

    localparam int THR_WIDTH  = 23;
    localparam int GAIN_WIDTH = 17;
    localparam int EST_WIDTH  = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int MB_WIDTH   = 19;
    localparam int FF_WIDTH   = 36;
    localparam int FF_HALF    = 18;
    localparam int RT_SHIFT   = 34;
    localparam int CNT_WIDTH  = 5;

    localparam logic [GAIN_WIDTH-1:0] GAIN_UNITY = 17'd65536;
    localparam logic [GAIN_WIDTH-1:0] NORM_CAP   = 17'd65536;
    localparam logic [EST_WIDTH-1:0]  EST_MAX    = 16'hFFFF;
    localparam logic [19:0]           PEAK_LEVEL = 20'd734003;
    localparam logic [15:0]           K_DECAY    = 16'd62259;
    localparam logic [15:0]           K_PEAK     = 16'd3277;
    localparam logic [15:0]           K_NORM     = 16'd19661;
    localparam logic [15:0]           K_BRIGHT   = 16'd45875;
    localparam logic [15:0]           ROUND_HALF = 16'd32768;
    localparam logic [18:0]           F1_BASE    = 19'd131072;
    localparam logic [17:0]           F2_BASE    = 18'd196608;

    localparam logic [CNT_WIDTH-1:0]  ATTACK_STEPS  = 5'd16;
    localparam logic [CNT_WIDTH-1:0]  RELEASE_STEPS = 5'd17;

    localparam int THR_RESET  = 1048576;
    localparam int BASE_RESET = 4800;
    localparam int MIN_RESET  = 480;
    localparam int MAX_RESET  = 48000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIMIT_THRESHOLD = 4'd0,
        REG_BASE_RELEASE    = 4'd1,
        REG_MIN_RELEASE     = 4'd2,
        REG_MAX_RELEASE     = 4'd3
    } arpl_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_PD,
        ST_MUL_NB,
        ST_MUL_BB,
        ST_UPD_BR,
        ST_MUL_FF,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACC_HI,
        ST_CLAMP,
        ST_DIV_LD,
        ST_DIV,
        ST_GAIN,
        ST_MUL_OUT,
        ST_OUT
    } arpl_state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_PD,
        MUL_NB,
        MUL_BB,
        MUL_FF,
        MUL_LO,
        MUL_HI,
        MUL_OUT
    } arpl_mul_t;

    typedef struct packed {
        arpl_mul_t mul_sel;
        logic      ld_x;
        logic      prep;
        logic      upd_pd;
        logic      ld_acc;
        logic      add_acc;
        logic      upd_br;
        logic      ld_ff;
        logic      ld_t;
        logic      div_start;
        logic      upd_gain;
        logic      ld_out;
    } arpl_ctrl_t;

    typedef struct packed {
        logic div_busy;
        logic out_busy;
    } arpl_stat_t;

endpackage

`default_nettype wire

/* rtl/arpl_if.sv */
// ----------------------------------------------------------------------------
// arpl_if
// Valid/ready channels of the limiter: sample words in, result words out,
// and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface arpl_in_if #(
    parameter int SAMPLE_WIDTH = 24
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink   (input valid, input in_sample, output ready);
endinterface

interface arpl_out_if #(
    parameter int SAMPLE_WIDTH = 24
);
    logic                                valid;
    logic                                ready;
    logic signed [SAMPLE_WIDTH-1:0]      out_sample;
    logic [arpl_pkg::GAIN_WIDTH-1:0]     applied_gain;

    modport source (output valid, output out_sample, output applied_gain, input ready);
    modport sink   (input valid, input out_sample, input applied_gain, output ready);
endinterface

interface arpl_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [arpl_pkg::CFG_IDX_W-1:0]  index;
    logic [arpl_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/adaptive_release_peak_limiter_top.sv */
// ----------------------------------------------------------------------------
// adaptive_release_peak_limiter_top
// One sample is in flight at a time: the next sample is accepted only once the
// previous one has passed the serial divider (one quotient bit per cycle), the
// shared multiplier (19-bit B operand) and reached the result word register.
// A waiting result word does not block the next sample from being accepted.
// Reset: asynchronous, active low; registers take their defaults, gain unity.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_release_peak_limiter_top #(
    parameter int SAMPLE_WIDTH  = 24,
    parameter int RELEASE_WIDTH = 18
) (
    input  logic         clk,
    input  logic         rst_n,
    arpl_cfg_if.sink     cfg,
    arpl_in_if.sink      samples,
    arpl_out_if.source   results
);
    import arpl_pkg::*;

    localparam int DIV_WIDTH = (SAMPLE_WIDTH > RELEASE_WIDTH + 1) ? SAMPLE_WIDTH
                                                                  : RELEASE_WIDTH + 1;

    arpl_ctrl_t              ctrl;
    arpl_stat_t              stat;
    logic                    in_ready;
    logic                    out_busy;
    logic                    div_busy;
    logic [DIV_WIDTH-1:0]    div_divisor;
    logic [DIV_WIDTH-1:0]    div_rem_init;
    logic [GAIN_WIDTH-1:0]   div_q_init;
    logic [CNT_WIDTH-1:0]    div_steps;
    logic [GAIN_WIDTH-1:0]   div_quotient;

    assign cfg.ready     = 1'b1;
    assign samples.ready = in_ready;
    assign stat.div_busy = div_busy;
    assign stat.out_busy = out_busy;

    arpl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .stat     (stat),
        .in_ready (in_ready),
        .ctrl     (ctrl)
    );

    arpl_dp #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .RELEASE_WIDTH (RELEASE_WIDTH),
        .DIV_WIDTH     (DIV_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .in_sample    (samples.in_sample),
        .ctrl         (ctrl),
        .out_ready    (results.ready),
        .out_valid    (results.valid),
        .out_sample   (results.out_sample),
        .applied_gain (results.applied_gain),
        .out_busy     (out_busy),
        .div_divisor  (div_divisor),
        .div_rem_init (div_rem_init),
        .div_q_init   (div_q_init),
        .div_steps    (div_steps),
        .div_quotient (div_quotient)
    );

    arpl_div #(
        .DIV_WIDTH (DIV_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.div_start),
        .divisor  (div_divisor),
        .rem_init (div_rem_init),
        .q_init   (div_q_init),
        .steps    (div_steps),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

endmodule

`default_nettype wire

/* rtl/arpl_div.sv */
// ----------------------------------------------------------------------------
// arpl_div
// Serial restoring divider, one quotient bit per cycle. The remainder may be
// preloaded so that a quotient of a shifted dividend needs fewer steps.
// ----------------------------------------------------------------------------
`default_nettype none

module arpl_div #(
    parameter int DIV_WIDTH = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [DIV_WIDTH-1:0]                divisor,
    input  logic [DIV_WIDTH-1:0]                rem_init,
    input  logic [arpl_pkg::GAIN_WIDTH-1:0]     q_init,
    input  logic [arpl_pkg::CNT_WIDTH-1:0]      steps,
    output logic                                busy,
    output logic [arpl_pkg::GAIN_WIDTH-1:0]     quotient
);
    import arpl_pkg::*;

    logic [DIV_WIDTH-1:0]  rem_reg, rem_next;
    logic [DIV_WIDTH-1:0]  div_reg;
    logic [GAIN_WIDTH-1:0] q_reg, q_next;
    logic [CNT_WIDTH-1:0]  cnt_reg;
    logic                  busy_reg;
    logic [DIV_WIDTH:0]    rem_sh;
    logic [DIV_WIDTH:0]    rem_sub;
    logic                  fits;

    assign rem_sh  = {rem_reg, q_reg[GAIN_WIDTH-1]};
    assign rem_sub = rem_sh - {1'b0, div_reg};
    assign fits    = rem_sh >= {1'b0, div_reg};

    always_comb
    begin
        rem_next = fits ? rem_sub[DIV_WIDTH-1:0] : rem_sh[DIV_WIDTH-1:0];
        q_next   = {q_reg[GAIN_WIDTH-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_WIDTH'(1);
            if (cnt_reg == CNT_WIDTH'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem_init;
            div_reg <= divisor;
            q_reg   <= q_init;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < div_reg))
        else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire

/* rtl/arpl_ctrl.sv */
// ----------------------------------------------------------------------------
// arpl_ctrl
// Sequencer of the limiter: steps one sample through the shared multiplier,
// the release-time clamp and the serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module arpl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  arpl_pkg::arpl_stat_t stat,
    output logic                 in_ready,
    output arpl_pkg::arpl_ctrl_t ctrl
);
    import arpl_pkg::*;

    arpl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    state_next = in_valid ? ST_PREP : ST_IDLE;
            ST_PREP:    state_next = ST_MUL_PD;
            ST_MUL_PD:  state_next = ST_MUL_NB;
            ST_MUL_NB:  state_next = ST_MUL_BB;
            ST_MUL_BB:  state_next = ST_UPD_BR;
            ST_UPD_BR:  state_next = ST_MUL_FF;
            ST_MUL_FF:  state_next = ST_MUL_LO;
            ST_MUL_LO:  state_next = ST_MUL_HI;
            ST_MUL_HI:  state_next = ST_ACC_HI;
            ST_ACC_HI:  state_next = ST_CLAMP;
            ST_CLAMP:   state_next = ST_DIV_LD;
            ST_DIV_LD:  state_next = ST_DIV;
            ST_DIV:     state_next = stat.div_busy ? ST_DIV : ST_GAIN;
            ST_GAIN:    state_next = ST_MUL_OUT;
            ST_MUL_OUT: state_next = ST_OUT;
            ST_OUT:     state_next = stat.out_busy ? ST_OUT : ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl         = '0;
        ctrl.mul_sel = MUL_NONE;
        in_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                ctrl.ld_x = in_valid;
            end
            ST_PREP:    ctrl.prep = 1'b1;
            ST_MUL_PD:  ctrl.mul_sel = MUL_PD;
            ST_MUL_NB:
            begin
                ctrl.mul_sel = MUL_NB;
                ctrl.upd_pd  = 1'b1;
            end
            ST_MUL_BB:
            begin
                ctrl.mul_sel = MUL_BB;
                ctrl.ld_acc  = 1'b1;
            end
            ST_UPD_BR:  ctrl.upd_br = 1'b1;
            ST_MUL_FF:  ctrl.mul_sel = MUL_FF;
            ST_MUL_LO:
            begin
                ctrl.mul_sel = MUL_LO;
                ctrl.ld_ff   = 1'b1;
            end
            ST_MUL_HI:
            begin
                ctrl.mul_sel = MUL_HI;
                ctrl.ld_acc  = 1'b1;
            end
            ST_ACC_HI:  ctrl.add_acc = 1'b1;
            ST_CLAMP:   ctrl.ld_t = 1'b1;
            ST_DIV_LD:  ctrl.div_start = 1'b1;
            ST_DIV:     ctrl.mul_sel = MUL_NONE;
            ST_GAIN:    ctrl.upd_gain = 1'b1;
            ST_MUL_OUT: ctrl.mul_sel = MUL_OUT;
            ST_OUT:
            begin
                ctrl.mul_sel = MUL_OUT;
                ctrl.ld_out  = !stat.out_busy;
            end
            default:    ctrl.mul_sel = MUL_NONE;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/arpl_dp.sv */
// ----------------------------------------------------------------------------
// arpl_dp
// Datapath of the limiter: registers, estimator updates, shared multiplier,
// release-time clamp, divider operands and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module arpl_dp #(
    parameter int SAMPLE_WIDTH  = 24,
    parameter int RELEASE_WIDTH = 18,
    parameter int DIV_WIDTH     = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [arpl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [arpl_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0]      in_sample,
    input  arpl_pkg::arpl_ctrl_t                ctrl,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic signed [SAMPLE_WIDTH-1:0]      out_sample,
    output logic [arpl_pkg::GAIN_WIDTH-1:0]     applied_gain,
    output logic                                out_busy,
    output logic [DIV_WIDTH-1:0]                div_divisor,
    output logic [DIV_WIDTH-1:0]                div_rem_init,
    output logic [arpl_pkg::GAIN_WIDTH-1:0]     div_q_init,
    output logic [arpl_pkg::CNT_WIDTH-1:0]      div_steps,
    input  logic [arpl_pkg::GAIN_WIDTH-1:0]     div_quotient
);
    import arpl_pkg::*;

    localparam int SW  = SAMPLE_WIDTH;
    localparam int RW  = RELEASE_WIDTH;
    localparam int MA  = (SW > RW + 1) ? ((SW > 20) ? SW : 20)
                                       : ((RW + 1 > 20) ? RW + 1 : 20);
    localparam int PW  = MA + MB_WIDTH;
    localparam int AW  = RW + FF_WIDTH;
    localparam int CW  = (SW > THR_WIDTH) ? SW : THR_WIDTH;
    localparam int TRW = RW + 2;
    localparam logic signed [PW-1:0] Y_MAX = PW'((64'sd1 <<< (SW - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] Y_MIN = -Y_MAX - PW'(1);

    logic [THR_WIDTH-1:0]  thr_reg;
    logic [RW-1:0]         base_reg;
    logic [RW-1:0]         min_reg;
    logic [RW-1:0]         max_reg;

    logic [GAIN_WIDTH-1:0] gain_reg;
    logic [EST_WIDTH-1:0]  pd_reg;
    logic [EST_WIDTH-1:0]  br_reg;
    logic signed [SW-1:0]  prev_reg;

    logic signed [SW-1:0]  x_reg;
    logic [SW-1:0]         mag_reg;
    logic [GAIN_WIDTH-1:0] norm_reg;
    logic                  peak_reg;
    logic                  attack_reg;
    logic signed [PW-1:0]  prod_reg;
    logic [AW-1:0]         acc_reg;
    logic [FF_WIDTH-1:0]   ff_reg;
    logic [RW-1:0]         t_reg;

    logic                  out_valid_reg;
    logic signed [SW-1:0]  out_sample_reg;
    logic [GAIN_WIDTH-1:0] out_gain_reg;

    logic signed [SW:0]    x_ext;
    logic signed [SW:0]    d_ext;
    logic [SW:0]           mag_w;
    logic [SW:0]           diff_w;
    logic [SW:0]           dsh_w;
    logic [GAIN_WIDTH-1:0] norm_w;
    logic [CW-1:0]         mag_cw;

    logic signed [MA-1:0]       mul_a;
    logic signed [MB_WIDTH-1:0] mul_b;
    logic [18:0]           f1_w;
    logic [17:0]           f2_w;

    logic [32:0]           pd_round;
    logic [17:0]           pd_sum;
    logic [EST_WIDTH-1:0]  pd_new;
    logic [33:0]           br_round;
    logic [17:0]           br_q;
    logic [EST_WIDTH-1:0]  br_new;

    logic [TRW-1:0]        t_raw;
    logic [TRW-1:0]        t_cap;
    logic [TRW-1:0]        t_clamped;

    logic signed [PW-1:0]  y_round;
    logic signed [PW-1:0]  y_shift;
    logic signed [SW-1:0]  y_sat;

    // sample magnitude and step size
    assign x_ext  = (SW + 1)'(x_reg);
    assign d_ext  = x_ext - (SW + 1)'(prev_reg);
    assign mag_w  = x_ext[SW] ? -x_ext : x_ext;
    assign diff_w = d_ext[SW] ? -d_ext : d_ext;
    assign dsh_w  = diff_w >> 3;
    assign norm_w = (dsh_w > (SW + 1)'(NORM_CAP)) ? NORM_CAP : dsh_w[GAIN_WIDTH-1:0];
    assign mag_cw = CW'(mag_w[SW-1:0]);

    // release factors
    assign f1_w = F1_BASE + 19'(pd_reg) + {2'b00, pd_reg, 1'b0};
    assign f2_w = F2_BASE - 18'(br_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (ctrl.mul_sel)
            MUL_NONE:
            begin
                mul_a = '0;
                mul_b = '0;
            end
            MUL_PD:
            begin
                mul_a = MA'(pd_reg);
                mul_b = MB_WIDTH'(K_DECAY);
            end
            MUL_NB:
            begin
                mul_a = MA'(norm_reg);
                mul_b = MB_WIDTH'(K_NORM);
            end
            MUL_BB:
            begin
                mul_a = MA'(br_reg);
                mul_b = MB_WIDTH'(K_BRIGHT);
            end
            MUL_FF:
            begin
                mul_a = MA'(f1_w);
                mul_b = MB_WIDTH'(f2_w);
            end
            MUL_LO:
            begin
                mul_a = MA'(base_reg);
                mul_b = MB_WIDTH'(prod_reg[FF_HALF-1:0]);
            end
            MUL_HI:
            begin
                mul_a = MA'(base_reg);
                mul_b = MB_WIDTH'(ff_reg[FF_WIDTH-1:FF_HALF]);
            end
            MUL_OUT:
            begin
                mul_a = MA'(x_reg);
                mul_b = MB_WIDTH'(gain_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // estimator updates
    assign pd_round = prod_reg[32:0] + 33'(ROUND_HALF);
    assign pd_sum   = {1'b0, pd_round[32:16]} + (peak_reg ? 18'(K_PEAK) : 18'd0);
    assign pd_new   = (pd_sum > 18'(EST_MAX)) ? EST_MAX : pd_sum[EST_WIDTH-1:0];
    assign br_round = acc_reg[33:0] + prod_reg[33:0] + 34'(ROUND_HALF);
    assign br_q     = br_round[33:16];
    assign br_new   = (br_q > 18'(EST_MAX)) ? EST_MAX : br_q[EST_WIDTH-1:0];

    // release time: cap to max first, then raise to min
    assign t_raw     = acc_reg[AW-1:RT_SHIFT];
    assign t_cap     = (t_raw > TRW'(max_reg)) ? TRW'(max_reg) : t_raw;
    assign t_clamped = (t_cap < TRW'(min_reg)) ? TRW'(min_reg) : t_cap;

    // divider operands
    assign div_divisor  = attack_reg ? DIV_WIDTH'(mag_reg)
                                     : DIV_WIDTH'(t_reg) + DIV_WIDTH'(1);
    assign div_rem_init = attack_reg ? DIV_WIDTH'(thr_reg) : '0;
    assign div_q_init   = attack_reg ? '0 : GAIN_UNITY - gain_reg;
    assign div_steps    = attack_reg ? ATTACK_STEPS : RELEASE_STEPS;

    // output rounding and saturation
    assign y_round = prod_reg + $signed(PW'(ROUND_HALF));
    assign y_shift = y_round >>> 16;
    assign y_sat   = (y_shift > Y_MAX) ? Y_MAX[SW-1:0] :
                     (y_shift < Y_MIN) ? Y_MIN[SW-1:0] : y_shift[SW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= THR_WIDTH'(THR_RESET);
            base_reg      <= RW'(BASE_RESET);
            min_reg       <= RW'(MIN_RESET);
            max_reg       <= RW'(MAX_RESET);
            gain_reg      <= GAIN_UNITY;
            pd_reg        <= '0;
            br_reg        <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (arpl_reg_t'(cfg_index))
                    REG_LIMIT_THRESHOLD: thr_reg  <= cfg_data[THR_WIDTH-1:0];
                    REG_BASE_RELEASE:    base_reg <= cfg_data[RW-1:0];
                    REG_MIN_RELEASE:     min_reg  <= cfg_data[RW-1:0];
                    REG_MAX_RELEASE:     max_reg  <= cfg_data[RW-1:0];
                    default:             thr_reg  <= thr_reg;
                endcase
            end
            if (ctrl.prep)
            begin
                prev_reg <= x_reg;
            end
            if (ctrl.upd_pd)
            begin
                pd_reg <= pd_new;
            end
            if (ctrl.upd_br)
            begin
                br_reg <= br_new;
            end
            if (ctrl.upd_gain)
            begin
                gain_reg <= attack_reg ? div_quotient : gain_reg + div_quotient;
            end
            if (ctrl.ld_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (ctrl.ld_x)
        begin
            x_reg <= in_sample;
        end
        if (ctrl.prep)
        begin
            mag_reg    <= mag_w[SW-1:0];
            norm_reg   <= norm_w;
            peak_reg   <= mag_cw > CW'(PEAK_LEVEL);
            attack_reg <= mag_cw > CW'(thr_reg);
        end
        if (ctrl.ld_acc)
        begin
            acc_reg <= AW'($unsigned(prod_reg));
        end
        else if (ctrl.add_acc)
        begin
            acc_reg <= acc_reg + (AW'($unsigned(prod_reg)) << FF_HALF);
        end
        if (ctrl.ld_ff)
        begin
            ff_reg <= prod_reg[FF_WIDTH-1:0];
        end
        if (ctrl.ld_t)
        begin
            t_reg <= t_clamped[RW-1:0];
        end
        if (ctrl.ld_out)
        begin
            out_sample_reg <= y_sat;
            out_gain_reg   <= gain_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_sample   = out_sample_reg;
    assign applied_gain = out_gain_reg;
    assign out_busy     = out_valid_reg && !out_ready;

`ifndef SYNTHESIS
    a_gain_max: assert property (@(posedge clk) disable iff (!rst_n)
        gain_reg <= GAIN_UNITY)
        else $error("gain above unity");

    a_release_rises: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.upd_gain && !attack_reg) |=> (gain_reg >= $past(gain_reg)))
        else $error("release step lowered the gain");

    a_attack_cuts: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.upd_gain && attack_reg) |=> (gain_reg < GAIN_UNITY))
        else $error("attack gain not below unity");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ld_out |-> !out_busy)
        else $error("result word overwritten before taken");
`endif

endmodule

`default_nettype wire
